// ===== rtl/nested_priority_task_dispatcher_assert.svh =====
// Assertion macros shared by the checker files of the task dispatcher.
// No dependencies; include this file before using the macros.
`ifndef NESTED_PRIORITY_TASK_DISPATCHER_ASSERT_SVH
`define NESTED_PRIORITY_TASK_DISPATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("npd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("npd assertion failed");

`endif

// ===== rtl/npd_pkg.sv =====
// Types and codes of the nested priority task dispatcher.
// No dependencies; the sequencer, the top level and the checker use this package.
package npd_pkg;

	// Widest priority field the design supports.
	localparam int PRIO_MAX_BITS = 16;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_COMPLETE = 2'd2
	} npd_cmd_t;

	typedef enum logic [2:0] {
		STAT_ADDED           = 3'd0,
		STAT_FULL            = 3'd1,
		STAT_DISPATCHED      = 3'd2,
		STAT_NONE_ELIGIBLE   = 3'd3,
		STAT_COMPLETED       = 3'd4,
		STAT_NOTHING_RUNNING = 3'd5
	} npd_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD_SCAN,
		ST_DISP_CHK,
		ST_CPL_LOAD,
		ST_FINISH
	} npd_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  task_priority;
		logic [63:0] handler_address;
		logic [63:0] handler_argument;
	} npd_request_t;

	typedef struct packed {
		npd_status_t status;
		logic [63:0] out_address;
		logic [63:0] out_argument;
		logic [7:0]  out_priority;
		logic [6:0]  pending_count;
	} npd_result_t;

endpackage

// ===== rtl/npd_channels.sv =====
// Request and response channel interfaces of the task dispatcher.
// No dependencies.
interface npd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  task_priority;
	logic [63:0] handler_address;
	logic [63:0] handler_argument;

	modport source (output valid, command, task_priority, handler_address, handler_argument,
		input ready);
	modport sink (input valid, command, task_priority, handler_address, handler_argument,
		output ready);
endinterface

interface npd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] out_address;
	logic [63:0] out_argument;
	logic [7:0]  out_priority;
	logic [6:0]  pending_count;

	modport source (output valid, status, out_address, out_argument, out_priority,
		pending_count, input ready);
	modport sink (input valid, status, out_address, out_argument, out_priority,
		pending_count, output ready);
endinterface

// ===== rtl/nested_priority_task_dispatcher.sv =====
// Nested priority task dispatcher: one command per request, one result per request, and
// requests are taken one at a time. An add moves each queued task less urgent than
// the new one a slot toward the tail, because the sorted queue lives in a RAM with one write
// and one read port and the sequencer moves one entry per cycle toward the tail. A dispatch
// reads the queue RAM, then compares the head with the running level, also when the head
// turns out not urgent enough, and a complete reads the stack RAM. An add to a full block, a
// dispatch with an empty queue or a full stack, a complete with nothing running and the
// unused command go straight to the result without a RAM step. The result sits in an
// output register, so the next request is taken while a result still waits for the sink;
// a further finished result waits in the sequencer until that register drains, and the
// input stalls meanwhile.
// Depends on npd_pkg, npd_channels and npd_seq.
module nested_priority_task_dispatcher #(
	parameter int CAPACITY      = 64,
	parameter int PRIORITY_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	npd_req_if.sink   req,
	npd_rsp_if.source rsp
);

	npd_pkg::npd_request_t req_data;
	npd_pkg::npd_result_t  res;
	npd_pkg::npd_result_t  rsp_data_q;
	logic                  res_valid;
	logic                  res_take;
	logic                  rsp_valid_q;

	assign req_data.command          = req.command;
	assign req_data.task_priority    = req.task_priority;
	assign req_data.handler_address  = req.handler_address;
	assign req_data.handler_argument = req.handler_argument;

	npd_seq #(.CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_data  (req_data),
		.req_ready (req.ready),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// A finished result moves into the output register once it is empty or being drained.
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_data_q.status;
	assign rsp.out_address   = rsp_data_q.out_address;
	assign rsp.out_argument  = rsp_data_q.out_argument;
	assign rsp.out_priority  = rsp_data_q.out_priority;
	assign rsp.pending_count = rsp_data_q.pending_count;

endmodule

// ===== rtl/npd_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies; used for the task queue and the nesting stack.
module npd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 136
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/npd_seq.sv =====
// Command sequencer of the task dispatcher: queue and stack RAMs, counters,
// and the single shared compare unit. Depends on npd_pkg and npd_ram.
module npd_seq #(
	parameter int CAPACITY      = 64,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  npd_pkg::npd_request_t req_data,
	output logic                 req_ready,
	output logic                 res_valid,
	output npd_pkg::npd_result_t res,
	input  logic                 res_take
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int LVL_W = PRIORITY_BITS + 1;
	localparam int ENT_W = PRIORITY_BITS + 128;

	npd_pkg::npd_state_t state_q, state_d;

	logic [1:0]               cmd_q, cmd_d;
	logic [PRIORITY_BITS-1:0] prio_q, prio_d;
	logic [63:0]              addr_q, addr_d;
	logic [63:0]              arg_q, arg_d;
	logic [IDX_W-1:0]         head_q, head_d;
	logic [IDX_W-1:0]         ptr_q, ptr_d;
	logic [CNT_W-1:0]         queued_q, queued_d;
	logic [CNT_W-1:0]         depth_q, depth_d;
	logic [CNT_W-1:0]         kcnt_q, kcnt_d;
	logic [LVL_W-1:0]         level_q, level_d;
	npd_pkg::npd_result_t     res_q, res_d;

	logic             q_we;
	logic [IDX_W-1:0] q_waddr, q_raddr;
	logic [ENT_W-1:0] q_wdata, q_rdata;
	logic             s_we;
	logic [IDX_W-1:0] s_waddr, s_raddr;
	logic [LVL_W-1:0] s_wdata, s_rdata;

	logic [PRIORITY_BITS-1:0]          rd_prio;
	logic [npd_pkg::PRIO_MAX_BITS-1:0] in_prio_ext, rd_prio_ext;
	logic [15:0]                       queued_ext;
	logic [SUM_W-1:0]                  tail_sum, occ_sum;
	logic [IDX_W-1:0]                  tail_idx;
	logic                              is_full;

	// Shared compare unit: a < b on level-wide operands.
	logic [LVL_W-1:0] cmp_a, cmp_b;
	logic             cmp_lt;

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
		idx_dec = (p == '0) ? IDX_W'(CAPACITY - 1) : IDX_W'(p - 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
		idx_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(p + 1'b1);
	endfunction

	npd_ram #(.DEPTH(CAPACITY), .WIDTH(ENT_W)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	npd_ram #(.DEPTH(CAPACITY), .WIDTH(LVL_W)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign rd_prio     = q_rdata[ENT_W-1 -: PRIORITY_BITS];
	assign rd_prio_ext = npd_pkg::PRIO_MAX_BITS'(rd_prio);
	assign in_prio_ext = npd_pkg::PRIO_MAX_BITS'(req_data.task_priority);
	assign queued_ext  = 16'(queued_q);

	assign occ_sum  = SUM_W'(queued_q) + SUM_W'(depth_q);
	assign is_full  = (occ_sum >= SUM_W'(CAPACITY));
	assign tail_sum = SUM_W'(head_q) + SUM_W'(queued_q);
	assign tail_idx = (tail_sum >= SUM_W'(CAPACITY)) ? IDX_W'(tail_sum - SUM_W'(CAPACITY))
		: IDX_W'(tail_sum);

	always_comb begin
		if (state_q == npd_pkg::ST_DISP_CHK) begin
			cmp_a = {1'b0, rd_prio};
			cmp_b = level_q;
		end else begin
			cmp_a = {1'b0, prio_q};
			cmp_b = {1'b0, rd_prio};
		end
		cmp_lt = (cmp_a < cmp_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= npd_pkg::ST_IDLE;
			head_q   <= '0;
			queued_q <= '0;
			depth_q  <= '0;
			level_q  <= {1'b1, {PRIORITY_BITS{1'b0}}};
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			queued_q <= queued_d;
			depth_q  <= depth_d;
			level_q  <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		prio_q <= prio_d;
		addr_q <= addr_d;
		arg_q  <= arg_d;
		ptr_q  <= ptr_d;
		kcnt_q <= kcnt_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		prio_d   = prio_q;
		addr_d   = addr_q;
		arg_d    = arg_q;
		head_d   = head_q;
		ptr_d    = ptr_q;
		queued_d = queued_q;
		depth_d  = depth_q;
		kcnt_d   = kcnt_q;
		level_d  = level_q;
		res_d    = res_q;

		q_we    = 1'b0;
		q_waddr = ptr_q;
		q_wdata = {prio_q, addr_q, arg_q};
		q_raddr = idx_dec(ptr_q);
		s_we    = 1'b0;
		s_waddr = depth_q[IDX_W-1:0];
		s_wdata = level_q;
		s_raddr = IDX_W'(depth_q - 1'b1);

		req_ready = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			npd_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd_d   = req_data.command;
					prio_d  = in_prio_ext[PRIORITY_BITS-1:0];
					addr_d  = req_data.handler_address;
					arg_d   = req_data.handler_argument;
					state_d = npd_pkg::ST_DECODE;
				end
			end
			npd_pkg::ST_DECODE: begin
				res_d   = '0;
				state_d = npd_pkg::ST_FINISH;
				case (cmd_q)
					npd_pkg::CMD_ADD: begin
						if (is_full) begin
							res_d.status = npd_pkg::STAT_FULL;
						end else begin
							// Scan from the tail toward the head, one entry a cycle.
							ptr_d   = tail_idx;
							kcnt_d  = queued_q;
							q_raddr = idx_dec(tail_idx);
							state_d = npd_pkg::ST_ADD_SCAN;
						end
					end
					npd_pkg::CMD_DISPATCH: begin
						if (queued_q == '0 || depth_q >= CNT_W'(CAPACITY)) begin
							res_d.status = npd_pkg::STAT_NONE_ELIGIBLE;
						end else begin
							q_raddr = head_q;
							state_d = npd_pkg::ST_DISP_CHK;
						end
					end
					npd_pkg::CMD_COMPLETE: begin
						if (depth_q == '0) begin
							res_d.status = npd_pkg::STAT_NOTHING_RUNNING;
						end else begin
							state_d = npd_pkg::ST_CPL_LOAD;
						end
					end
					default: begin
						res_d.status = npd_pkg::STAT_NONE_ELIGIBLE;
					end
				endcase
			end
			npd_pkg::ST_ADD_SCAN: begin
				q_we = 1'b1;
				if (kcnt_q != '0 && cmp_lt) begin
					// The entry above is less urgent: move it one slot toward the tail.
					q_wdata = q_rdata;
					ptr_d   = idx_dec(ptr_q);
					kcnt_d  = CNT_W'(kcnt_q - 1'b1);
					q_raddr = idx_dec(idx_dec(ptr_q));
				end else begin
					queued_d     = CNT_W'(queued_q + 1'b1);
					res_d.status = npd_pkg::STAT_ADDED;
					state_d      = npd_pkg::ST_FINISH;
				end
			end
			npd_pkg::ST_DISP_CHK: begin
				state_d = npd_pkg::ST_FINISH;
				if (cmp_lt) begin
					s_we               = 1'b1;
					depth_d            = CNT_W'(depth_q + 1'b1);
					level_d            = {1'b0, rd_prio};
					head_d             = idx_inc(head_q);
					queued_d           = CNT_W'(queued_q - 1'b1);
					res_d.status       = npd_pkg::STAT_DISPATCHED;
					res_d.out_address  = q_rdata[127:64];
					res_d.out_argument = q_rdata[63:0];
					res_d.out_priority = rd_prio_ext[7:0];
				end else begin
					res_d.status = npd_pkg::STAT_NONE_ELIGIBLE;
				end
			end
			npd_pkg::ST_CPL_LOAD: begin
				level_d      = s_rdata;
				depth_d      = CNT_W'(depth_q - 1'b1);
				res_d.status = npd_pkg::STAT_COMPLETED;
				state_d      = npd_pkg::ST_FINISH;
			end
			npd_pkg::ST_FINISH: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = npd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = npd_pkg::ST_IDLE;
			end
		endcase

		res               = res_q;
		res.pending_count = queued_ext[6:0];
	end

endmodule

// ===== rtl/npd_checker.sv =====
// Port-level checker of the task dispatcher and its bind to the top level.
// Depends on npd_pkg and nested_priority_task_dispatcher_assert.svh.
`include "nested_priority_task_dispatcher_assert.svh"

module npd_checker #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [63:0] out_address,
	input logic [63:0] out_argument,
	input logic [7:0]  out_priority,
	input logic [6:0]  pending_count
);

	logic       code_ok;
	logic       plain_rsp;
	logic       payload_zero;
	logic       rsp_stalled;
	logic [9:0] rsp_key;

	assign code_ok      = (status <= npd_pkg::STAT_NOTHING_RUNNING);
	assign plain_rsp    = rsp_valid && (status != npd_pkg::STAT_DISPATCHED);
	assign payload_zero = (out_address == 64'd0) && (out_argument == 64'd0)
		&& (out_priority == 8'd0);
	assign rsp_stalled  = rsp_valid && !rsp_ready;
	assign rsp_key      = {status, pending_count};

	// Every status code is one of the defined results.
	`NPD_ASSERT_IMPLY(a_status_code, clk, arst_n, rsp_valid, code_ok)

	// Only a successful dispatch carries task data.
	`NPD_ASSERT_IMPLY(a_zero_payload, clk, arst_n, plain_rsp, payload_zero)

	// The queue never reports more waiting tasks than it has slots.
	`NPD_ASSERT_IMPLY(a_count_bound, clk, arst_n, rsp_valid, pending_count <= CAPACITY)

	// The block works on one request at a time.
	`NPD_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	// A stalled result holds.
	`NPD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stalled, rsp_valid && $stable(rsp_key))

endmodule

bind nested_priority_task_dispatcher npd_checker #(.CAPACITY(CAPACITY)) u_npd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.out_address   (rsp.out_address),
	.out_argument  (rsp.out_argument),
	.out_priority  (rsp.out_priority),
	.pending_count (rsp.pending_count)
);
